// ----- src/rhcm_pkg.sv -----
// Package for the rectification homography coordinate map.
// Holds register indexes, fixed widths, reset values and shared types; no dependencies.
package rhcm_pkg;

    // Coefficient and output formats
    localparam int COEF_W  = 48;
    localparam int IN_W    = 12;
    localparam int OUT_W   = 24;
    localparam int NUM_REG = 8;
    localparam int IDX_W   = 3;
    localparam int ONE_SHIFT = 28;

    // Register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_XU = 3'd0,
        REG_XV = 3'd1,
        REG_X0 = 3'd2,
        REG_YU = 3'd3,
        REG_YV = 3'd4,
        REG_Y0 = 3'd5,
        REG_WU = 3'd6,
        REG_WV = 3'd7
    } rhcm_reg_t;

    // Reset values, Q20.28
    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << ONE_SHIFT;
    localparam logic [COEF_W-1:0] COEF_ZERO = '0;

    // Saturation limits of a coordinate
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Flags carried along with a word through the divider cells
    typedef struct packed {
        logic neg;   // quotient sign
        logic ovf;   // integer part too large
        logic wz;    // w was zero
    } rhcm_side_t;

endpackage

// ----- src/rectify_homography_coord_map.sv -----
// Rectification map generator: maps a rectified pixel (u,v) through an inverse
// homography to the source position x/w, y/w. One word is taken every clock cycle
// while in_stall is low, and passes the multiply, sum, magnitude and divider entry
// stages, then a chain of 25 + OUT_FRAC_BITS division cells, one quotient bit per
// cell, then the output register. Both channels pause together only while a
// finished result is held on a stalled output. Coefficients are Q20.28, written
// through the plain register port; the user must write them only while the block
// is idle, which the block itself does not enforce. Results are signed Q16.8
// (OUT_FRAC_BITS fraction bits), rounded half away from zero and clamped, with
// w_zero flagging a zero w and saturated flagging a clamp.
// Depends on rhcm_pkg, rhcm_divider and rhcm_div_cell.
module rectify_homography_coord_map #(
    parameter int COORD_BITS    = 12,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [rhcm_pkg::IDX_W-1:0]        cfg_index,
    input  logic [rhcm_pkg::COEF_W-1:0]       cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rhcm_pkg::IN_W-1:0]         rect_col,
    input  logic [rhcm_pkg::IN_W-1:0]         rect_row,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rhcm_pkg::OUT_W-1:0] src_x,
    output logic signed [rhcm_pkg::OUT_W-1:0] src_y,
    output logic                              w_zero,
    output logic                              saturated
);

    localparam int CW = rhcm_pkg::COEF_W;
    localparam int UW = (COORD_BITS < rhcm_pkg::IN_W) ? COORD_BITS : rhcm_pkg::IN_W;
    localparam int PW = CW + UW + 1;           // product width
    localparam int SW = CW + UW + 2;           // sum width
    localparam int OW = rhcm_pkg::OUT_W;

    // Coefficient registers
    logic [CW-1:0] coef_reg [rhcm_pkg::NUM_REG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[rhcm_pkg::REG_XU] <= rhcm_pkg::COEF_ONE;
            coef_reg[rhcm_pkg::REG_XV] <= rhcm_pkg::COEF_ZERO;
            coef_reg[rhcm_pkg::REG_X0] <= rhcm_pkg::COEF_ZERO;
            coef_reg[rhcm_pkg::REG_YU] <= rhcm_pkg::COEF_ZERO;
            coef_reg[rhcm_pkg::REG_YV] <= rhcm_pkg::COEF_ONE;
            coef_reg[rhcm_pkg::REG_Y0] <= rhcm_pkg::COEF_ZERO;
            coef_reg[rhcm_pkg::REG_WU] <= rhcm_pkg::COEF_ZERO;
            coef_reg[rhcm_pkg::REG_WV] <= rhcm_pkg::COEF_ZERO;
        end
        else if (cfg_wr_en)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Global advance: hold every pipeline stage while a result waits on a stalled output
    logic adv;
    logic out_valid_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign adv      = ~in_stall;

    // Stage 1: products
    logic signed [UW:0]   u_s, v_s;
    logic                 s1_valid_reg;
    logic signed [PW-1:0] p_xu_reg, p_xv_reg, p_yu_reg, p_yv_reg, p_wu_reg, p_wv_reg;

    assign u_s = {1'b0, rect_col[UW-1:0]};
    assign v_s = {1'b0, rect_row[UW-1:0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_xu_reg <= $signed(coef_reg[rhcm_pkg::REG_XU]) * u_s;
            p_xv_reg <= $signed(coef_reg[rhcm_pkg::REG_XV]) * v_s;
            p_yu_reg <= $signed(coef_reg[rhcm_pkg::REG_YU]) * u_s;
            p_yv_reg <= $signed(coef_reg[rhcm_pkg::REG_YV]) * v_s;
            p_wu_reg <= $signed(coef_reg[rhcm_pkg::REG_WU]) * u_s;
            p_wv_reg <= $signed(coef_reg[rhcm_pkg::REG_WV]) * v_s;
        end
    end

    // Stage 2: sums
    logic                 s2_valid_reg;
    logic signed [SW-1:0] x_reg, y_reg, w_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= SW'(p_xu_reg) + SW'(p_xv_reg)
                     + SW'($signed(coef_reg[rhcm_pkg::REG_X0]));
            y_reg <= SW'(p_yu_reg) + SW'(p_yv_reg)
                     + SW'($signed(coef_reg[rhcm_pkg::REG_Y0]));
            w_reg <= SW'(p_wu_reg) + SW'(p_wv_reg)
                     + SW'($signed({1'b0, rhcm_pkg::COEF_ONE}));
        end
    end

    // Stage 3: magnitudes and signs
    logic          s3_valid_reg;
    logic [SW-1:0] xm_reg, ym_reg, wm_reg;
    logic          xneg_reg, yneg_reg, wz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm_reg   <= x_reg[SW-1] ? SW'(-x_reg) : SW'(x_reg);
            ym_reg   <= y_reg[SW-1] ? SW'(-y_reg) : SW'(y_reg);
            wm_reg   <= w_reg[SW-1] ? SW'(-w_reg) : SW'(w_reg);
            xneg_reg <= x_reg[SW-1] ^ w_reg[SW-1];
            yneg_reg <= y_reg[SW-1] ^ w_reg[SW-1];
            wz_reg   <= (w_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Dividers for x and y
    logic          dx_vld, dy_vld, dx_sat, dy_sat, dx_wz, dy_wz;
    logic [OW-1:0] dx_res, dy_res;

    rhcm_divider #(
        .AW        (SW),
        .FRAC_BITS (OUT_FRAC_BITS)
    ) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s3_valid_reg),
        .num_mag (xm_reg),
        .den_mag (wm_reg),
        .neg     (xneg_reg),
        .wz      (wz_reg),
        .res_vld (dx_vld),
        .res     (dx_res),
        .res_sat (dx_sat),
        .res_wz  (dx_wz)
    );

    rhcm_divider #(
        .AW        (SW),
        .FRAC_BITS (OUT_FRAC_BITS)
    ) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s3_valid_reg),
        .num_mag (ym_reg),
        .den_mag (wm_reg),
        .neg     (yneg_reg),
        .wz      (wz_reg),
        .res_vld (dy_vld),
        .res     (dy_res),
        .res_sat (dy_sat),
        .res_wz  (dy_wz)
    );

    // Output register
    logic [OW-1:0] src_x_reg, src_y_reg;
    logic          w_zero_reg, saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dx_vld & dy_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            src_x_reg     <= dx_res;
            src_y_reg     <= dy_res;
            w_zero_reg    <= dx_wz | dy_wz;
            saturated_reg <= dx_sat | dy_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign src_x     = $signed(src_x_reg);
    assign src_y     = $signed(src_y_reg);
    assign w_zero    = w_zero_reg;
    assign saturated = saturated_reg;

endmodule

// ----- src/rhcm_div_cell.sv -----
// One cell of the long-division chain: yields one quotient bit per word.
// Depends on rhcm_pkg.
module rhcm_div_cell #(
    parameter int RW = 62,
    parameter int NB = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                prev_valid,
    input  logic [RW-1:0]       prev_rem,
    input  logic [NB-1:0]       prev_low,
    input  logic [NB-1:0]       prev_quo,
    input  logic [RW-1:0]       prev_div,
    input  rhcm_pkg::rhcm_side_t prev_side,
    output logic                cur_valid,
    output logic [RW-1:0]       cur_rem,
    output logic [NB-1:0]       cur_low,
    output logic [NB-1:0]       cur_quo,
    output logic [RW-1:0]       cur_div,
    output rhcm_pkg::rhcm_side_t cur_side
);

    logic                 valid_reg;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [NB-1:0]        low_reg, low_next;
    logic [NB-1:0]        quo_reg, quo_next;
    logic [RW-1:0]        div_reg;
    rhcm_pkg::rhcm_side_t side_reg;
    logic [RW:0]          trial;
    logic [RW:0]          diff;
    logic                 ge;

    // Bring down the next dividend bit, trial subtract
    always_comb
    begin
        trial    = {prev_rem, prev_low[NB-1]};
        diff     = trial - {1'b0, prev_div};
        ge       = (trial >= {1'b0, prev_div});
        rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
        low_next = {prev_low[NB-2:0], 1'b0};
        quo_next = {prev_quo[NB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quo_reg  <= quo_next;
            div_reg  <= prev_div;
            side_reg <= prev_side;
        end
    end

    assign cur_valid = valid_reg;
    assign cur_rem   = rem_reg;
    assign cur_low   = low_reg;
    assign cur_quo   = quo_reg;
    assign cur_div   = div_reg;
    assign cur_side  = side_reg;

endmodule

// ----- src/rhcm_divider.sv -----
// Pipelined magnitude divider: entry stage, a chain of division cells, rounding, sign and clamp.
// Depends on rhcm_pkg and rhcm_div_cell.
module rhcm_divider #(
    parameter int AW        = 62,
    parameter int FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  logic [AW-1:0]               num_mag,
    input  logic [AW-1:0]               den_mag,
    input  logic                        neg,
    input  logic                        wz,
    output logic                        res_vld,
    output logic [rhcm_pkg::OUT_W-1:0]  res,
    output logic                        res_sat,
    output logic                        res_wz
);

    localparam int OW = rhcm_pkg::OUT_W;
    localparam int NB = OW + FRAC_BITS + 1;   // quotient bits incl. rounding bit

    // Entry stage
    logic                 e_valid_reg;
    logic [AW-1:0]        e_rem_reg;
    logic [NB-1:0]        e_low_reg;
    logic [AW-1:0]        e_div_reg;
    rhcm_pkg::rhcm_side_t e_side_reg;
    logic [AW-1:0]        hi_part;

    assign hi_part = num_mag >> OW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_rem_reg      <= hi_part;
            e_low_reg      <= {num_mag[OW-1:0], {(FRAC_BITS+1){1'b0}}};
            e_div_reg      <= den_mag;
            e_side_reg.neg <= neg;
            e_side_reg.wz  <= wz;
            e_side_reg.ovf <= (hi_part >= den_mag);
        end
    end

    // Cell chain
    logic                 s_valid [0:NB];
    logic [AW-1:0]        s_rem   [0:NB];
    logic [NB-1:0]        s_low   [0:NB];
    logic [NB-1:0]        s_quo   [0:NB];
    logic [AW-1:0]        s_div   [0:NB];
    rhcm_pkg::rhcm_side_t s_side  [0:NB];

    assign s_valid[0] = e_valid_reg;
    assign s_rem[0]   = e_rem_reg;
    assign s_low[0]   = e_low_reg;
    assign s_quo[0]   = '0;
    assign s_div[0]   = e_div_reg;
    assign s_side[0]  = e_side_reg;

    for (genvar k = 0; k < NB; k++)
    begin : g_cell
        rhcm_div_cell #(
            .RW (AW),
            .NB (NB)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (s_valid[k]),
            .prev_rem   (s_rem[k]),
            .prev_low   (s_low[k]),
            .prev_quo   (s_quo[k]),
            .prev_div   (s_div[k]),
            .prev_side  (s_side[k]),
            .cur_valid  (s_valid[k+1]),
            .cur_rem    (s_rem[k+1]),
            .cur_low    (s_low[k+1]),
            .cur_quo    (s_quo[k+1]),
            .cur_div    (s_div[k+1]),
            .cur_side   (s_side[k+1])
        );
    end

    // Round half away from zero, then apply sign and clamp
    logic [NB:0]          q_inc;
    logic [NB-1:0]        mag;
    rhcm_pkg::rhcm_side_t side_l;

    always_comb
    begin
        side_l  = s_side[NB];
        q_inc   = {1'b0, s_quo[NB]} + (NB+1)'(1);
        mag     = q_inc[NB:1];
        res     = '0;
        res_sat = 1'b0;
        if (side_l.wz)
        begin
            res     = '0;
            res_sat = 1'b0;
        end
        else if (side_l.ovf)
        begin
            res     = side_l.neg ? rhcm_pkg::OUT_MIN : rhcm_pkg::OUT_MAX;
            res_sat = 1'b1;
        end
        else if (side_l.neg)
        begin
            if (mag > NB'(rhcm_pkg::OUT_MIN))
            begin
                res     = rhcm_pkg::OUT_MIN;
                res_sat = 1'b1;
            end
            else
            begin
                res = OW'(~mag + NB'(1));
            end
        end
        else
        begin
            if (mag > NB'(rhcm_pkg::OUT_MAX))
            begin
                res     = rhcm_pkg::OUT_MAX;
                res_sat = 1'b1;
            end
            else
            begin
                res = mag[OW-1:0];
            end
        end
    end

    assign res_vld = s_valid[NB];
    assign res_wz  = side_l.wz;

endmodule

// ----- tb/sv/tb_rectify_homography_coord_map.sv -----
// Testbench for rectify_homography_coord_map: directed and random coordinate words
// checked against an in-bench inverse homography predictor with random idling.
// Depends on rhcm_pkg and the block itself.
module tb_rectify_homography_coord_map;

    localparam int FRAC_BITS = 8;
    localparam int DRAIN_CYCLES = 48;

    typedef struct {
        logic signed [rhcm_pkg::OUT_W-1:0] x;
        logic signed [rhcm_pkg::OUT_W-1:0] y;
        logic                              wz;
        logic                              sat;
    } src_pos_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [rhcm_pkg::IDX_W-1:0]        cfg_index;
    logic [rhcm_pkg::COEF_W-1:0]       cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [rhcm_pkg::IN_W-1:0]         rect_col;
    logic [rhcm_pkg::IN_W-1:0]         rect_row;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [rhcm_pkg::OUT_W-1:0] src_x;
    logic signed [rhcm_pkg::OUT_W-1:0] src_y;
    logic                              w_zero;
    logic                              saturated;

    // Predictor copy of the coefficient registers, sign extended
    longint   coef [rhcm_pkg::NUM_REG];
    src_pos_t pending_pos [$];
    int       error_count;
    bit       calm;
    int       stall_left;

    rectify_homography_coord_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rect_col  (rect_col),
        .rect_row  (rect_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .src_x     (src_x),
        .src_y     (src_y),
        .w_zero    (w_zero),
        .saturated (saturated)
    );

    always #10 clk = ~clk;

    // Divide, round half away from zero, clamp to the output range
    function automatic logic signed [rhcm_pkg::OUT_W-1:0] divide_round(input longint num,
                                                                        input longint den,
                                                                        inout bit sat);
        bit          neg;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = a / b;
        r = a % b;
        if (q >= (64'd1 << rhcm_pkg::OUT_W))
        begin
            sat = 1'b1;
            return neg ? rhcm_pkg::OUT_MIN : rhcm_pkg::OUT_MAX;
        end
        for (int i = 0; i < FRAC_BITS + 1; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        m = (q + 1) >> 1;
        if (neg)
        begin
            if (m > (64'd1 << (rhcm_pkg::OUT_W - 1)))
            begin
                sat = 1'b1;
                return rhcm_pkg::OUT_MIN;
            end
            return -m[rhcm_pkg::OUT_W-1:0];
        end
        if (m > {40'd0, rhcm_pkg::OUT_MAX})
        begin
            sat = 1'b1;
            return rhcm_pkg::OUT_MAX;
        end
        return m[rhcm_pkg::OUT_W-1:0];
    endfunction

    // Source position of one rectified pixel
    function automatic src_pos_t map_pixel(input logic [rhcm_pkg::IN_W-1:0] u,
                                           input logic [rhcm_pkg::IN_W-1:0] v);
        src_pos_t res;
        longint   x;
        longint   y;
        longint   w;
        longint   lu;
        longint   lv;
        bit       sat;
        lu = longint'(u);
        lv = longint'(v);
        x = coef[rhcm_pkg::REG_XU] * lu + coef[rhcm_pkg::REG_XV] * lv
            + coef[rhcm_pkg::REG_X0];
        y = coef[rhcm_pkg::REG_YU] * lu + coef[rhcm_pkg::REG_YV] * lv
            + coef[rhcm_pkg::REG_Y0];
        w = coef[rhcm_pkg::REG_WU] * lu + coef[rhcm_pkg::REG_WV] * lv
            + (longint'(1) << rhcm_pkg::ONE_SHIFT);
        sat = 1'b0;
        res.x = '0;
        res.y = '0;
        res.wz = (w == 0);
        if (!res.wz)
        begin
            res.x = divide_round(x, w, sat);
            res.y = divide_round(y, w, sat);
        end
        res.sat = sat;
        return res;
    endfunction

    // Random signed value that fits in the given number of bits
    function automatic logic [rhcm_pkg::COEF_W-1:0] rand_coef(input int bits);
        logic [63:0] r;
        longint      s;
        r = {$urandom, $urandom};
        s = longint'(r) >>> (64 - bits);
        return s[rhcm_pkg::COEF_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Register write, only while the block is idle
    task automatic write_coef(input rhcm_pkg::rhcm_reg_t idx,
                              input logic [rhcm_pkg::COEF_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        coef[idx] = longint'($signed(value));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_coefs(input logic [rhcm_pkg::COEF_W-1:0] xu, xv, x0, yu, yv, y0,
                              wu, wv);
        write_coef(rhcm_pkg::REG_XU, xu);
        write_coef(rhcm_pkg::REG_XV, xv);
        write_coef(rhcm_pkg::REG_X0, x0);
        write_coef(rhcm_pkg::REG_YU, yu);
        write_coef(rhcm_pkg::REG_YV, yv);
        write_coef(rhcm_pkg::REG_Y0, y0);
        write_coef(rhcm_pkg::REG_WU, wu);
        write_coef(rhcm_pkg::REG_WV, wv);
    endtask

    // Send one word; called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [rhcm_pkg::IN_W-1:0] u,
                             input logic [rhcm_pkg::IN_W-1:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rect_col <= u;
        rect_row <= v;
        do
            @(posedge clk);
        while (in_stall);
        pending_pos.push_back(map_pixel(u, v));
        @(negedge clk);
    endtask

    // Called at a falling edge: drop valid at once, then wait for the pipe to empty
    task automatic drain;
        in_valid <= 1'b0;
        wait (pending_pos.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Output stall: random hold per result, none while calm
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        src_pos_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_pos.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 0);
            end
            else
            begin
                want = pending_pos.pop_front();
                if (src_x !== want.x)
                    report_mismatch("src_x", src_x, want.x);
                if (src_y !== want.y)
                    report_mismatch("src_y", src_y, want.y);
                if (w_zero !== want.wz)
                    report_mismatch("w_zero", w_zero, want.wz);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
            stall_left = calm ? 0 : $urandom_range(0, 7);
        end
    end

    // Reset coefficients: identity map
    task automatic test_identity;
        send_word(12'd0, 12'd0);
        send_word(12'd4095, 12'd4095);
        send_word(12'd4095, 12'd0);
        send_word(12'd0, 12'd4095);
        send_word(12'd1, 12'd2);
        send_word(12'd2730, 12'd1365);
        drain();
    endtask

    // w exactly zero, and w just off zero
    task automatic test_w_zero;
        load_coefs(rhcm_pkg::COEF_ONE, rhcm_pkg::COEF_ZERO, rhcm_pkg::COEF_ZERO,
                   rhcm_pkg::COEF_ZERO, rhcm_pkg::COEF_ONE, rhcm_pkg::COEF_ZERO,
                   -(rhcm_pkg::COEF_W'(1) << 18), rhcm_pkg::COEF_ZERO);
        send_word(12'd1024, 12'd7);
        send_word(12'd1023, 12'd5);
        send_word(12'd1025, 12'd4095);
        drain();
    endtask

    // Coefficient extremes drive both coordinates to the clamps
    task automatic test_saturation;
        load_coefs({1'b0, {47{1'b1}}}, {1'b1, 47'd0}, {1'b0, {47{1'b1}}},
                   {1'b1, 47'd0}, {1'b0, {47{1'b1}}}, {1'b1, 47'd0},
                   rhcm_pkg::COEF_ZERO, rhcm_pkg::COEF_ZERO);
        send_word(12'd4095, 12'd0);
        send_word(12'd0, 12'd4095);
        send_word(12'd0, 12'd0);
        drain();
    endtask

    // Half-LSB ties and negative w
    task automatic test_rounding;
        load_coefs(rhcm_pkg::COEF_ONE, rhcm_pkg::COEF_ZERO, rhcm_pkg::COEF_W'(1) << 19,
                   rhcm_pkg::COEF_ZERO, rhcm_pkg::COEF_ONE,
                   -(rhcm_pkg::COEF_W'(1) << 19), rhcm_pkg::COEF_ZERO,
                   -(rhcm_pkg::COEF_W'(1) << 17));
        send_word(12'd0, 12'd0);
        send_word(12'd3, 12'd4095);
        send_word(12'd4095, 12'd2048);
        send_word(12'd17, 12'd2047);
        drain();
    endtask

    // Random phases over several coefficient sets
    task automatic test_random;
        logic [rhcm_pkg::IN_W-1:0] u;
        for (int p = 0; p < 10; p++)
        begin
            calm = (p % 3 == 0);
            case (p % 4)
                0: load_coefs(rand_coef(31), rand_coef(31), rand_coef(41), rand_coef(31),
                              rand_coef(31), rand_coef(41), rhcm_pkg::COEF_ZERO,
                              rhcm_pkg::COEF_ZERO);
                1: load_coefs(rand_coef(31), rand_coef(31), rand_coef(41), rand_coef(31),
                              rand_coef(31), rand_coef(41), rand_coef(17), rand_coef(17));
                2: load_coefs(rand_coef(48), rand_coef(48), rand_coef(48), rand_coef(48),
                              rand_coef(48), rand_coef(48), rand_coef(48), rand_coef(48));
                default: load_coefs(rand_coef(31), rand_coef(31), rand_coef(41),
                                    rand_coef(31), rand_coef(31), rand_coef(41),
                                    -(rhcm_pkg::COEF_W'(1) << 18), rhcm_pkg::COEF_ZERO);
            endcase
            for (int i = 0; i < 55; i++)
            begin
                u = $urandom_range(0, 4095);
                if (p % 4 == 3 && $urandom_range(0, 2) == 0)
                    u = 12'd1024;
                send_word(u, $urandom_range(0, 4095));
            end
            drain();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        rect_col    = '0;
        rect_row    = '0;
        out_stall   = 1'b0;
        stall_left  = 0;
        calm        = 1'b0;
        error_count = 0;
        foreach (coef[i])
            coef[i] = 0;
        coef[rhcm_pkg::REG_XU] = longint'(1) << rhcm_pkg::ONE_SHIFT;
        coef[rhcm_pkg::REG_YV] = longint'(1) << rhcm_pkg::ONE_SHIFT;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_identity();
        test_w_zero();
        test_saturation();
        test_rounding();
        test_random();

        if (error_count == 0)
            $display("tb_rectify_homography_coord_map passed");
        else
            $display("tb_rectify_homography_coord_map failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #4000000;
        $display("tb_rectify_homography_coord_map failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rhcm_pkg.sv
src/rhcm_div_cell.sv
src/rhcm_divider.sv
src/rectify_homography_coord_map.sv
tb/sv/tb_rectify_homography_coord_map.sv
